// ===== src/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package deq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int CMD_W           = 3;
  localparam int WORD_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int OUT_COUNT_W     = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
    logic [OUT_COUNT_W-1:0]   entry_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic capture;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;
  } dp_stat_t;

endpackage

// ===== src/deq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/deq_datapath.sv =====
// Ring-buffer pointers, entry count, storage and result register of the queue.
module deq_datapath #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::in_word_t  in_word,
  input  deq_pkg::dp_cmd_t   ctl,
  output deq_pkg::dp_stat_t  stat,
  output deq_pkg::out_word_t out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] front_up, front_dn, back_up, back_dn;

  logic signed [deq_pkg::WORD_W-1:0] data_out_r, data_out_nxt;
  logic [deq_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [deq_pkg::OUT_COUNT_W-1:0]   ecount_r, ecount_nxt;

  logic                  wr_en, rd_en, needs_read;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic                  held_none, is_full;

  logic signed [63:0] rd_wide;

  assign front_up = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign front_dn = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign back_up  = (back_r == LAST_IDX) ? '0 : back_r + AW'(1);
  assign back_dn  = (back_r == '0) ? LAST_IDX : back_r - AW'(1);

  assign held_none = (count_r == '0);
  assign is_full   = (count_r == FULL_CNT);

  // Only the low DATA_WIDTH bits of the pushed word are kept.
  assign wr_data = DATA_WIDTH'($unsigned(in_word.data_in));

  always_comb begin
    front_nxt    = front_r;
    back_nxt     = back_r;
    count_nxt    = count_r;
    wr_en        = 1'b0;
    wr_addr      = back_r;
    rd_addr      = front_r;
    needs_read   = 1'b0;
    data_out_nxt = '0;
    status_nxt   = deq_pkg::STATUS_OK;
    case (in_word.cmd)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = deq_pkg::STATUS_FULL;
        end else begin
          front_nxt = front_dn;
          wr_addr   = front_dn;
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = deq_pkg::STATUS_FULL;
        end else begin
          back_nxt  = back_up;
          wr_addr   = back_r;
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (!held_none) begin
          rd_addr    = front_r;
          needs_read = 1'b1;
          front_nxt  = front_up;
          count_nxt  = count_r - CW'(1);
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (!held_none) begin
          rd_addr    = back_dn;
          needs_read = 1'b1;
          back_nxt   = back_dn;
          count_nxt  = count_r - CW'(1);
        end
      end
      deq_pkg::CMD_PEEK_FRONT: begin
        rd_addr    = front_r;
        needs_read = !held_none;
      end
      deq_pkg::CMD_PEEK_BACK: begin
        rd_addr    = back_dn;
        needs_read = !held_none;
      end
      default: begin
      end
    endcase
    // Pops and peeks on an empty queue answer -1 with the empty status.
    if (in_word.cmd inside {deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
                            deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK}
        && held_none) begin
      status_nxt   = deq_pkg::STATUS_EMPTY;
      data_out_nxt = -32'sd1;
    end
    ecount_nxt = deq_pkg::OUT_COUNT_W'(count_nxt);
  end

  assign stat.needs_read = needs_read;
  assign rd_en           = ctl.take && needs_read;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctl.take && wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stored words are sign-extended from DATA_WIDTH bits on the way out.
  assign rd_wide = 64'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (ctl.take) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      data_out_r <= data_out_nxt;
      status_r   <= status_nxt;
      ecount_r   <= ecount_nxt;
    end else if (ctl.capture) begin
      data_out_r <= rd_wide[deq_pkg::WORD_W-1:0];
    end
  end

  assign out_word.data_out    = data_out_r;
  assign out_word.status      = status_r;
  assign out_word.entry_count = ecount_r;

endmodule

// ===== src/deq_ctrl.sv =====
// Controller state machine that sequences one command through the datapath.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  deq_pkg::dp_stat_t stat,
  output deq_pkg::dp_cmd_t  ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_ready    = (state_r == ST_IDLE);
  assign take        = in_valid && in_ready;
  assign ctl.take    = take;
  assign ctl.capture = (state_r == ST_READ);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (stat.needs_read) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt     = ST_RESP;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        // The registered RAM word is captured into the result this cycle.
        state_nxt     = ST_RESP;
        out_valid_nxt = 1'b1;
      end
      ST_RESP: begin
        if (out_ready) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/double_ended_queue.sv =====
// Timing: a push, an ignored code, or a pop or peek on an empty queue shows its word in the
// cycle after acceptance; a pop or peek that reads the store passes the RAM read register
// and then the result register. A new command is accepted only once the last word is taken.
// Reset (synchronous, rst_n low): front and back pointers and the entry count go to zero and
// no result is pending; the store's contents are not cleared and are only read once written.
// Top level of the double-ended queue: controller, datapath and storage.
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_word_t out_word
);

  deq_pkg::dp_cmd_t  ctl;
  deq_pkg::dp_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .ctl      (ctl),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
